### rtl/rdfc8_pkg.sv
// Shared types, constants and the CRC-8 step for the datagram framer.
package rdfc8_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RX    = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_e;

  typedef enum logic {
    REG_NODE_ADDR = 1'b0,
    REG_TIMEOUT   = 1'b1
  } reg_idx_e;

  localparam int unsigned AddrW     = 7;
  localparam int unsigned TimeoutW  = 10;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned CntW      = 4;
  localparam int unsigned FrameLen  = 7;   // data bytes held before the CRC byte

  localparam logic [7:0]          SyncByte     = 8'h05;
  localparam logic [7:0]          WriteFlag    = 8'h80;
  localparam logic [7:0]          CrcPoly      = 8'h07;
  localparam logic [TimeoutW-1:0] TimeoutReset = 10'd200;
  localparam logic [TimeoutW-1:0] TimeoutMax   = 10'd1023;
  localparam logic [CntW-1:0]     WriteLen     = 4'd8;
  localparam logic [CntW-1:0]     ReadLen      = 4'd4;
  localparam logic [CntW-1:0]     ReplyLast    = 4'd7;
  localparam logic [CntW-1:0]     ReplyDataPos = 4'd4;

  // MSB-first CRC-8 over one byte.
  function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] c;
    logic       top;
    crc = crc_in;
    c   = data;
    for (int b = 0; b < 8; b++) begin
      top = crc[7] ^ c[7];
      crc = {crc[6:0], 1'b0};
      if (top) begin
        crc = crc ^ CrcPoly;
      end
      c = {c[6:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

### rtl/register_datagram_framer_crc8_unit.sv
// Datagram framer: request framing with CRC-8, reply assembly and reply timeout.
// Latency: the first result word is offered the cycle after its item is accepted.
// Throughput: a write request yields 8 words and a read request 4, one word per cycle while
// m_axis_tready_i is high; the next item is taken in the cycle the last word is taken.
// The output frame register sets this.
// Reset (rst_ni low, async): idle, no pending read, node address 0, timeout 200 ticks.
module register_datagram_framer_crc8_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [rdfc8_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [7:0] reg_addr, [39:8] write_value, [47:40] rx_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] tx_byte, [39:8] read_value
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o
);

  // Unpack the input word.
  logic [7:0]  reg_addr;
  logic [31:0] write_value;
  logic [7:0]  rx_byte;
  rdfc8_pkg::cmd_e cmd;

  assign reg_addr    = s_axis_tdata_i[7:0];
  assign write_value = s_axis_tdata_i[39:8];
  assign rx_byte     = s_axis_tdata_i[47:40];
  assign cmd         = rdfc8_pkg::cmd_e'(s_axis_tuser_i);

  // Configuration registers.
  logic [rdfc8_pkg::AddrW-1:0]    node_addr_q;
  logic [rdfc8_pkg::TimeoutW-1:0] timeout_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q   <= '0;
      timeout_lim_q <= rdfc8_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      case (rdfc8_pkg::reg_idx_e'(cfg_idx_i))
        rdfc8_pkg::REG_NODE_ADDR: node_addr_q   <= cfg_data_i[rdfc8_pkg::AddrW-1:0];
        rdfc8_pkg::REG_TIMEOUT:   timeout_lim_q <= cfg_data_i[rdfc8_pkg::TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // Reply tracking state.
  logic                           awaiting_q, awaiting_d;
  logic [rdfc8_pkg::CntW-1:0]     reply_cnt_q, reply_cnt_d;
  logic [31:0]                    reply_val_q, reply_val_d;
  logic [rdfc8_pkg::TimeoutW-1:0] tick_cnt_q, tick_cnt_d;

  // Output frame register: pending words, oldest at index 0.
  logic [7:0]                 bytes_q [rdfc8_pkg::FrameLen];
  logic [7:0]                 bytes_d [rdfc8_pkg::FrameLen];
  logic [rdfc8_pkg::CntW-1:0] cnt_q, cnt_d;      // words still to send
  rdfc8_pkg::kind_e           kind_q, kind_d;
  logic [31:0]                val_q, val_d;
  logic [7:0]                 crc_q, crc_d;      // running CRC over words already sent

  logic s_fire, m_fire, last_word;

  assign last_word       = (cnt_q == rdfc8_pkg::CntW'(1));
  assign m_fire          = m_axis_tvalid_o && m_axis_tready_i;
  // Take a new item once the frame is empty or its final word leaves this cycle.
  assign s_axis_tready_o = (cnt_q == '0) || (last_word && m_axis_tready_i);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  logic [rdfc8_pkg::CntW-1:0]     reply_cnt_inc;
  logic [31:0]                    reply_val_shift;
  logic [rdfc8_pkg::TimeoutW-1:0] tick_cnt_inc;

  assign reply_cnt_inc   = reply_cnt_q + rdfc8_pkg::CntW'(1);
  assign reply_val_shift = (reply_cnt_q >= rdfc8_pkg::ReplyDataPos) ?
                           {reply_val_q[23:0], rx_byte} : reply_val_q;
  assign tick_cnt_inc    = (tick_cnt_q < rdfc8_pkg::TimeoutMax) ?
                           tick_cnt_q + rdfc8_pkg::TimeoutW'(1) : tick_cnt_q;

  always_comb begin
    awaiting_d  = awaiting_q;
    reply_cnt_d = reply_cnt_q;
    reply_val_d = reply_val_q;
    tick_cnt_d  = tick_cnt_q;
    bytes_d     = bytes_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    val_d       = val_q;
    crc_d       = crc_q;

    // Advance the frame: drop the word taken and fold it into the CRC.
    if (m_fire) begin
      for (int i = 0; i < rdfc8_pkg::FrameLen - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
      bytes_d[rdfc8_pkg::FrameLen-1] = '0;
      crc_d = rdfc8_pkg::crc8_byte(crc_q, bytes_q[0]);
      cnt_d = cnt_q - rdfc8_pkg::CntW'(1);
    end

    if (s_fire) begin
      case (cmd)
        rdfc8_pkg::CMD_WRITE, rdfc8_pkg::CMD_READ: begin
          // A request abandons any pending read.
          reply_cnt_d = '0;
          reply_val_d = '0;
          tick_cnt_d  = '0;
          awaiting_d  = (cmd == rdfc8_pkg::CMD_READ);
          bytes_d[0]  = rdfc8_pkg::SyncByte;
          bytes_d[2]  = reg_addr;
          kind_d      = rdfc8_pkg::KIND_TX;
          val_d       = '0;
          crc_d       = '0;
          if (cmd == rdfc8_pkg::CMD_WRITE) begin
            bytes_d[1] = rdfc8_pkg::WriteFlag | {1'b0, node_addr_q};
            bytes_d[3] = write_value[31:24];
            bytes_d[4] = write_value[23:16];
            bytes_d[5] = write_value[15:8];
            bytes_d[6] = write_value[7:0];
            cnt_d      = rdfc8_pkg::WriteLen;
          end else begin
            bytes_d[1] = {1'b0, node_addr_q};
            bytes_d[3] = '0;
            bytes_d[4] = '0;
            bytes_d[5] = '0;
            bytes_d[6] = '0;
            cnt_d      = rdfc8_pkg::ReadLen;
          end
        end
        rdfc8_pkg::CMD_RX: begin
          if (awaiting_q) begin
            reply_val_d = reply_val_shift;
            reply_cnt_d = reply_cnt_inc;
            if (reply_cnt_q == rdfc8_pkg::ReplyLast) begin
              // Eighth reply byte: hand back the value and go idle.
              awaiting_d  = 1'b0;
              reply_cnt_d = '0;
              reply_val_d = '0;
              tick_cnt_d  = '0;
              kind_d      = rdfc8_pkg::KIND_VALUE;
              val_d       = reply_val_shift;
              cnt_d       = rdfc8_pkg::CntW'(1);
            end
          end
        end
        rdfc8_pkg::CMD_TICK: begin
          if (awaiting_q) begin
            tick_cnt_d = tick_cnt_inc;
            if (tick_cnt_inc >= timeout_lim_q) begin
              awaiting_d  = 1'b0;
              reply_cnt_d = '0;
              reply_val_d = '0;
              tick_cnt_d  = '0;
              kind_d      = rdfc8_pkg::KIND_TIMEOUT;
              val_d       = '0;
              cnt_d       = rdfc8_pkg::CntW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b0;
      reply_cnt_q <= '0;
      reply_val_q <= '0;
      tick_cnt_q  <= '0;
      cnt_q       <= '0;
      kind_q      <= rdfc8_pkg::KIND_TX;
    end else begin
      awaiting_q  <= awaiting_d;
      reply_cnt_q <= reply_cnt_d;
      reply_val_q <= reply_val_d;
      tick_cnt_q  <= tick_cnt_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    val_q   <= val_d;
    crc_q   <= crc_d;
  end

  // Present the head word; the final word of a datagram is the CRC.
  logic [7:0] tx_byte;

  always_comb begin
    tx_byte = bytes_q[0];
    if (kind_q != rdfc8_pkg::KIND_TX) begin
      tx_byte = '0;
    end else if (last_word) begin
      tx_byte = crc_q;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {val_q, tx_byte};
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = last_word;

`ifndef SYNTHESIS
  // The frame never holds more words than a write datagram.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rdfc8_pkg::WriteLen)
    else $error("frame word count out of range");

  // A read or timeout result is always a single, final word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (kind_q != rdfc8_pkg::KIND_TX)) |-> last_word)
    else $error("reply result is not a single word");

  // An accepted read request leaves a pending read behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (cmd == rdfc8_pkg::CMD_READ)) |=> (awaiting_q && (cnt_q == rdfc8_pkg::ReadLen)))
    else $error("read request not tracked");

  // Input is stalled only while result words are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty frame");
`endif

endmodule
